// File: rtl/bpq_pkg.sv
package bpq_pkg;

	// payload field types
	typedef logic [1:0] func_t;
	typedef logic [1:0] status_t;
	typedef logic [7:0] node_t;
	typedef logic [3:0] cost_t;

	// configuration register widths
	localparam int NODE_COUNT_W = 9;
	localparam int LEVELS_W     = 5;
	localparam int CFG_DATA_W   = 9;

	typedef logic [0:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// register indexes
	localparam cfg_index_t CFG_NODE_COUNT  = 1'd0;
	localparam cfg_index_t CFG_COST_LEVELS = 1'd1;

	// operation codes
	localparam func_t FUNC_CLEAR = 2'd0;
	localparam func_t FUNC_POP   = 2'd1;
	localparam func_t FUNC_DEC   = 2'd2;

	// result status codes
	localparam status_t STAT_DONE      = 2'd0;
	localparam status_t STAT_EMPTY     = 2'd1;
	localparam status_t STAT_NOT_LOWER = 2'd2;
	localparam status_t STAT_RANGE     = 2'd3;

endpackage

// File: rtl/bpq_if.sv
interface bpq_req_if;
	import bpq_pkg::*;

	logic  valid;
	logic  ready;
	func_t func;
	node_t node;
	cost_t cost;

	modport source (output valid, output func, output node, output cost, input ready);
	modport sink   (input valid, input func, input node, input cost, output ready);
endinterface

interface bpq_rsp_if;
	import bpq_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	node_t   out_node;
	cost_t   out_cost;

	modport source (output valid, output status, output out_node, output out_cost, input ready);
	modport sink   (input valid, input status, input out_node, input out_cost, output ready);
endinterface

// File: rtl/bpq_ram.sv
module bpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// one registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/bucket_priority_queue.sv
// Bucket priority queue: a monotone min-queue of nodes with small integer costs.
// Input words arrive on req (func, node, cost) and one result word per input
// leaves on rsp (status, out_node, out_cost); both use valid/ready.
// node_count and cost_levels are written through cfg_we/cfg_index/cfg_wdata
// only while the block is idle, a rule on the user that the block does not
// enforce; a write takes effect with the next operation. One word is handled
// at a time, with ready low while busy:
//   clear, unused code, empty pop, node out of range: result loaded on accept;
//   pop: the result follows the registered slot/cost memory read.
//   clear then sweeps all MAX_NODES slots (one slot per cycle through the
//     slot/map memories) before the next word.
//   decrease key: the node's slot and cost are read; a cost that is not lower
//     ends it, else the cost blocks are walked down with swaps as needed.
// Reset clears the control state and then runs the same sweep over all
// MAX_NODES slots with ready low; configuration writes are taken meanwhile.
// The result sits in an output register; while it waits, ready stays low
// unless the receiver takes it in the same cycle, so a stalled receiver
// holds the input off.
module bucket_priority_queue #(
	parameter int MAX_NODES  = 256,
	parameter int MAX_LEVELS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  bpq_pkg::cfg_index_t  cfg_index,
	input  bpq_pkg::cfg_data_t   cfg_wdata,
	bpq_req_if.sink              req,
	bpq_rsp_if.source            rsp
);
	import bpq_pkg::*;

	localparam int NW  = $clog2(MAX_NODES);
	localparam int PW  = $clog2(MAX_NODES + 1);
	localparam int CW  = (PW > NODE_COUNT_W) ? PW : NODE_COUNT_W;
	localparam int LVL = (MAX_LEVELS < 16) ? MAX_LEVELS : 16;
	localparam int LIW = $clog2(LVL);
	localparam logic [3:0] RST_TOP = 4'(LVL - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SWEEP = 3'd1;
	localparam logic [2:0] S_POPRD = 3'd2;
	localparam logic [2:0] S_NSLOT = 3'd3;
	localparam logic [2:0] S_OLD   = 3'd4;
	localparam logic [2:0] S_WALK  = 3'd5;
	localparam logic [2:0] S_CHK   = 3'd6;
	localparam logic [2:0] S_SWB   = 3'd7;

	logic [2:0]              state_q;
	logic [NW-1:0]           sweep_q;
	logic [PW-1:0]           pp_q;
	logic [PW-1:0]           bs_q [LVL];
	logic [NODE_COUNT_W-1:0] nc_q;
	logic [LEVELS_W-1:0]     cl_q;
	logic [3:0]              top_q;
	logic [NW-1:0]           idx_q;
	logic [NW-1:0]           na_q;
	logic [NW-1:0]           s_q;
	logic                    s_ok_q;
	cost_t                   cost_q;
	logic [3:0]              lvl_q;
	logic                    ov_q;
	status_t                 ost_q;
	node_t                   onode_q;
	cost_t                   ocost_q;

	// memory ports
	logic          sn_we, ns_we, sc_we;
	logic [NW-1:0] sn_wa, ns_wa, sc_wa;
	logic [NW-1:0] sn_wd, ns_wd;
	logic [3:0]    sc_wd;
	logic [NW-1:0] sn_ra, ns_ra;
	logic [NW-1:0] sn_rd, ns_rd;
	logic [3:0]    sc_rd;

	logic [CW-1:0]       eff_nodes;
	logic [LEVELS_W-1:0] eff_levels;
	logic [3:0]          top_now;
	logic                acc;
	logic                pp_ok;
	logic                node_ok;
	logic [PW-1:0]       bs_cur;
	logic                bs_room;
	logic                lvl_in;
	logic                do_swap;
	logic                load_out;
	status_t             ld_status;
	node_t               ld_node;
	cost_t               ld_cost;

	bpq_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_slot_node (
		.clk(clk), .we(sn_we), .waddr(sn_wa), .wdata(sn_wd), .raddr(sn_ra), .rdata(sn_rd)
	);

	bpq_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_slot (
		.clk(clk), .we(ns_we), .waddr(ns_wa), .wdata(ns_wd), .raddr(ns_ra), .rdata(ns_rd)
	);

	bpq_ram #(.WIDTH(4), .DEPTH(MAX_NODES)) u_slot_cost (
		.clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(sn_ra), .rdata(sc_rd)
	);

	// effective register values
	always_comb begin
		eff_nodes = (CW'(nc_q) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(nc_q);
		eff_levels = (cl_q > LEVELS_W'(LVL)) ? LEVELS_W'(LVL) : cl_q;
		if (eff_levels == '0) begin
			eff_levels = LEVELS_W'(1);
		end
		top_now = 4'(eff_levels - LEVELS_W'(1));
	end

	assign acc      = req.valid && req.ready;
	assign pp_ok    = (CW'(pp_q) < eff_nodes) && (pp_q < PW'(MAX_NODES));
	assign node_ok  = (CW'(req.node) < eff_nodes) && (CW'(req.node) < CW'(MAX_NODES));
	assign bs_cur   = bs_q[lvl_q[LIW-1:0]];
	assign bs_room  = bs_cur < PW'(MAX_NODES);
	assign lvl_in   = {1'b0, lvl_q} < 5'(LVL);
	assign do_swap  = s_ok_q && (s_q != idx_q) && (sc_rd == lvl_q);

	assign req.ready    = (state_q == S_IDLE) && (!ov_q || rsp.ready);
	assign rsp.valid    = ov_q;
	assign rsp.status   = ost_q;
	assign rsp.out_node = onode_q;
	assign rsp.out_cost = ocost_q;

	// read addresses
	always_comb begin
		ns_ra = NW'(req.node);
		case (state_q)
			S_NSLOT: sn_ra = ns_rd;
			S_WALK:  sn_ra = NW'(bs_cur);
			default: sn_ra = NW'(pp_q);
		endcase
	end

	// write ports: sweep, key update and the two halves of a swap
	always_comb begin
		sn_we = 1'b0;
		ns_we = 1'b0;
		sc_we = 1'b0;
		sn_wa = idx_q;
		ns_wa = idx_q;
		sc_wa = idx_q;
		sn_wd = idx_q;
		ns_wd = idx_q;
		sc_wd = cost_q;
		case (state_q)
			S_SWEEP: begin
				sn_we = 1'b1;
				ns_we = 1'b1;
				sc_we = 1'b1;
				sn_wa = sweep_q;
				ns_wa = sweep_q;
				sc_wa = sweep_q;
				sn_wd = sweep_q;
				ns_wd = sweep_q;
				sc_wd = top_q;
			end
			S_OLD: begin
				sc_we = cost_q < sc_rd;
			end
			S_CHK: begin
				sn_we = do_swap;
				ns_we = do_swap;
				sc_we = do_swap;
				sn_wd = sn_rd;
				ns_wa = sn_rd;
				ns_wd = idx_q;
				sc_wd = lvl_q;
			end
			S_SWB: begin
				sn_we = 1'b1;
				ns_we = 1'b1;
				sc_we = 1'b1;
				sn_wa = s_q;
				sc_wa = s_q;
				sn_wd = na_q;
				ns_wa = na_q;
				ns_wd = s_q;
			end
			default: begin
			end
		endcase
	end

	// result loading
	always_comb begin
		load_out  = 1'b0;
		ld_status = STAT_DONE;
		ld_node   = '0;
		ld_cost   = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.func)
						FUNC_CLEAR: load_out = 1'b1;
						FUNC_POP: begin
							load_out  = !pp_ok;
							ld_status = STAT_EMPTY;
						end
						FUNC_DEC: begin
							load_out  = !node_ok;
							ld_status = STAT_RANGE;
						end
						default: load_out = 1'b1;
					endcase
				end
			end
			S_POPRD: begin
				load_out = 1'b1;
				ld_node  = 8'(sn_rd);
				ld_cost  = sc_rd;
			end
			S_OLD: begin
				load_out  = cost_q >= sc_rd;
				ld_status = STAT_NOT_LOWER;
			end
			S_WALK: begin
				load_out = lvl_q <= cost_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			sweep_q <= '0;
			pp_q    <= '0;
			for (int i = 0; i < LVL; i++) begin
				bs_q[i] <= '0;
			end
			nc_q    <= NODE_COUNT_W'(256);
			cl_q    <= LEVELS_W'(16);
			top_q   <= RST_TOP;
			idx_q   <= '0;
			na_q    <= '0;
			s_q     <= '0;
			s_ok_q  <= 1'b0;
			cost_q  <= '0;
			lvl_q   <= '0;
			ov_q    <= 1'b0;
			ost_q   <= STAT_DONE;
			onode_q <= '0;
			ocost_q <= '0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_NODE_COUNT:  nc_q <= cfg_wdata[NODE_COUNT_W-1:0];
					CFG_COST_LEVELS: cl_q <= cfg_wdata[LEVELS_W-1:0];
					default: begin
					end
				endcase
			end

			// output register
			if (rsp.valid && rsp.ready) begin
				ov_q <= 1'b0;
			end
			if (load_out) begin
				ov_q    <= 1'b1;
				ost_q   <= ld_status;
				onode_q <= ld_node;
				ocost_q <= ld_cost;
			end

			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (req.func)
							FUNC_CLEAR: begin
								state_q <= S_SWEEP;
								sweep_q <= '0;
								top_q   <= top_now;
								pp_q    <= '0;
								for (int i = 0; i < LVL; i++) begin
									bs_q[i] <= '0;
								end
							end
							FUNC_POP: begin
								if (pp_ok) begin
									state_q <= S_POPRD;
								end
							end
							FUNC_DEC: begin
								cost_q <= req.cost;
								if (node_ok) begin
									state_q <= S_NSLOT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + NW'(1);
					if (sweep_q == NW'(MAX_NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_POPRD: begin
					pp_q    <= pp_q + PW'(1);
					state_q <= S_IDLE;
				end
				S_NSLOT: begin
					idx_q   <= ns_rd;
					state_q <= S_OLD;
				end
				S_OLD: begin
					if (cost_q >= sc_rd) begin
						state_q <= S_IDLE;
					end else begin
						na_q    <= sn_rd;
						lvl_q   <= sc_rd;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (lvl_q <= cost_q) begin
						state_q <= S_IDLE;
					end else if (!lvl_in) begin
						lvl_q <= lvl_q - 4'd1;
					end else begin
						s_q     <= NW'(bs_cur);
						s_ok_q  <= bs_room;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (do_swap) begin
						state_q <= S_SWB;
					end else begin
						if (bs_room) begin
							bs_q[lvl_q[LIW-1:0]] <= bs_cur + PW'(1);
						end
						lvl_q   <= lvl_q - 4'd1;
						state_q <= S_WALK;
					end
				end
				S_SWB: begin
					idx_q <= s_q;
					if (bs_room) begin
						bs_q[lvl_q[LIW-1:0]] <= bs_cur + PW'(1);
					end
					lvl_q   <= lvl_q - 4'd1;
					state_q <= S_WALK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a new result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!ov_q || rsp.ready))
		else $error("result register overwritten");

	// pop pointer stays within the slot store
	a_pp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pp_q <= PW'(MAX_NODES))
		else $error("pop pointer past slot store");

	// a clear always starts the memory sweep
	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.func == FUNC_CLEAR) |=> (state_q == S_SWEEP && sweep_q == '0))
		else $error("clear did not start sweep");

	// the second half of a swap follows a check that found a swap
	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWB) |-> ($past(state_q) == S_CHK && $past(do_swap)))
		else $error("swap half without check");

	// the walk never moves below the new cost
	a_walk_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK || state_q == S_SWB) |-> (lvl_q > cost_q))
		else $error("walk below new cost");
`endif

endmodule
